[hdl/key_value_line_tokenizer_core_assert.svh]
// Assertion macros shared by the tokenizer RTL.
`ifndef KEY_VALUE_LINE_TOKENIZER_CORE_ASSERT_SVH
`define KEY_VALUE_LINE_TOKENIZER_CORE_ASSERT_SVH
`ifndef SYNTH
`define KVLT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tokenizer assertion failed");
`define KVLT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tokenizer assertion failed");
`else
`define KVLT_ASSERT(lbl, prop)
`define KVLT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[hdl/kvlt_pkg.sv]
// Types and constants of the key:value line tokenizer.
package kvlt_pkg;

  localparam logic [4:0] FIELD_LIMIT = 5'd20;
  localparam logic [6:0] STORE_LIMIT = 7'd100;

  // configuration register indexes
  localparam logic CFG_FIELD_LIM = 1'b0;
  localparam logic CFG_MAX_LEN   = 1'b1;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    KIND_KEY_CHAR   = 3'd0,
    KIND_KEY_DONE   = 3'd1,
    KIND_VAL_CHAR   = 3'd2,
    KIND_FIELD_DONE = 3'd3,
    KIND_ABANDON    = 3'd4,
    KIND_LINE_DONE  = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic [6:0] char_pos;
    logic [4:0] field_pos;
    logic [6:0] final_len;
    logic [4:0] fields_found;
    logic       last;
  } result_t;

endpackage

[hdl/key_value_line_tokenizer_core.sv]
// Key:value line tokenizer: parser state, result queue and stream ports.
// Results are visible on the master side in the cycle after their request is
// accepted, when the result queue is empty.
// Throughput: one line byte per cycle while s_axis_tready is high; an
// end-of-line request gives up to two results, held in a four-entry queue.
// s_axis_tready drops while fewer than two queue slots are free.
// Reset: rst_ni low clears the parser, empties the queue and restores the
// field limit to 20 and max_len to 100; no clearing pass follows.
`include "key_value_line_tokenizer_core_assert.svh"
module key_value_line_tokenizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] line_byte
  input  logic        s_axis_tuser_i,   // [0] req_type
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] out_char, [14:8] char_pos, [19:15] field_pos, [26:20] final_len,
  // [31:27] fields_found
  output logic [31:0] m_axis_tdata_o,
  output logic [2:0]  m_axis_tuser_o,   // [2:0] out_kind
  output logic        m_axis_tlast_o    // last_of_run
);

  localparam logic [2:0] PH_SKIP   = 3'd0;
  localparam logic [2:0] PH_KEY    = 3'd1;
  localparam logic [2:0] PH_VSTART = 3'd2;
  localparam logic [2:0] PH_UNQ    = 3'd3;
  localparam logic [2:0] PH_QUOTED = 3'd4;

  logic [4:0] field_lim_q;
  logic [6:0] max_len_q;
  logic [2:0] phase_q, phase_d;
  logic [4:0] field_total_q, field_total_d;
  logic [6:0] raw_count_q, raw_count_d;
  logic [6:0] kept_count_q, kept_count_d;
  logic       halted_q, halted_d;

  kvlt_pkg::result_t queue_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q;

  kvlt_pkg::result_t res0, res1, fd_res, head;
  logic [1:0] n_res;
  logic       in_acc, out_acc;
  logic [4:0] field_cap, ft_inc;
  logic [6:0] len_lim, char_cap, key_len, val_len, raw_inc;
  logic       stopped, raw_room, fd_halt, is_eol;
  logic [7:0] ch;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (cnt_q <= 3'd2);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;
  assign ch              = s_axis_tdata_i;
  assign is_eol          = s_axis_tuser_i;

  assign field_cap = (field_lim_q > kvlt_pkg::FIELD_LIMIT) ? kvlt_pkg::FIELD_LIMIT
                                                            : field_lim_q;
  assign len_lim   = (max_len_q > kvlt_pkg::STORE_LIMIT) ? kvlt_pkg::STORE_LIMIT : max_len_q;
  assign char_cap  = (len_lim == 7'd0) ? 7'd0 : len_lim - 7'd1;
  assign stopped   = halted_q || (field_total_q >= field_cap);
  assign ft_inc    = field_total_q + 5'd1;
  assign key_len   = (raw_count_q > char_cap) ? char_cap : raw_count_q;
  assign val_len   = (kept_count_q > char_cap) ? char_cap : kept_count_q;
  assign raw_room  = (raw_count_q < char_cap);
  assign raw_inc   = raw_count_q + 7'd1;
  assign fd_halt   = (ft_inc >= field_cap);

  always_comb begin
    fd_res              = '0;
    fd_res.kind         = kvlt_pkg::KIND_FIELD_DONE;
    fd_res.field_pos    = field_total_q;
    fd_res.final_len    = val_len;
    fd_res.fields_found = ft_inc;
  end

  always_comb begin
    phase_d       = phase_q;
    field_total_d = field_total_q;
    raw_count_d   = raw_count_q;
    kept_count_d  = kept_count_q;
    halted_d      = halted_q;
    res0          = '0;
    res1          = '0;
    n_res         = 2'd0;
    res0.fields_found = field_total_q;
    res0.field_pos    = field_total_q;

    if (is_eol) begin
      res1.kind         = kvlt_pkg::KIND_LINE_DONE;
      res1.fields_found = field_total_q;
      if (!stopped && phase_q == PH_KEY) begin
        res0.kind = kvlt_pkg::KIND_ABANDON;
        n_res     = 2'd2;
      end else if (!stopped && (phase_q == PH_VSTART || phase_q == PH_UNQ ||
                                phase_q == PH_QUOTED)) begin
        res0              = fd_res;
        res1.fields_found = ft_inc;
        n_res             = 2'd2;
      end else begin
        res0              = '0;
        res0.kind         = kvlt_pkg::KIND_LINE_DONE;
        res0.fields_found = field_total_q;
        n_res             = 2'd1;
      end
      // start the next line from scratch
      phase_d       = PH_SKIP;
      field_total_d = '0;
      raw_count_d   = '0;
      kept_count_d  = '0;
      halted_d      = 1'b0;
    end else if (!stopped) begin
      unique case (phase_q)
        PH_SKIP: begin
          if (ch != kvlt_pkg::CH_SPACE && ch != kvlt_pkg::CH_LF && ch != kvlt_pkg::CH_CR) begin
            raw_count_d  = '0;
            kept_count_d = '0;
            if (ch == kvlt_pkg::CH_COLON) begin
              res0.kind      = kvlt_pkg::KIND_KEY_DONE;
              res0.final_len = '0;
              n_res          = 2'd1;
              phase_d        = PH_VSTART;
            end else begin
              phase_d = PH_KEY;
              if (char_cap != 7'd0) begin
                res0.kind   = kvlt_pkg::KIND_KEY_CHAR;
                res0.ch     = ch;
                n_res       = 2'd1;
                raw_count_d = 7'd1;
              end
            end
          end
        end
        PH_KEY: begin
          if (ch == kvlt_pkg::CH_COLON) begin
            res0.kind      = kvlt_pkg::KIND_KEY_DONE;
            res0.final_len = key_len;
            n_res          = 2'd1;
            raw_count_d    = '0;
            kept_count_d   = '0;
            phase_d        = PH_VSTART;
          end else if (raw_room) begin
            res0.kind     = kvlt_pkg::KIND_KEY_CHAR;
            res0.ch       = ch;
            res0.char_pos = raw_count_q;
            n_res         = 2'd1;
            raw_count_d   = raw_inc;
          end
        end
        PH_VSTART, PH_UNQ, PH_QUOTED: begin
          if ((phase_q == PH_VSTART && ch == kvlt_pkg::CH_QUOTE)) begin
            phase_d = PH_QUOTED;
          end else if ((phase_q != PH_QUOTED && ch == kvlt_pkg::CH_SPACE) ||
                       (phase_q == PH_QUOTED && ch == kvlt_pkg::CH_QUOTE)) begin
            res0          = fd_res;
            n_res         = 2'd1;
            field_total_d = ft_inc;
            raw_count_d   = '0;
            kept_count_d  = '0;
            phase_d       = PH_SKIP;
            if (fd_halt) halted_d = 1'b1;
          end else begin
            if (phase_q == PH_VSTART) phase_d = PH_UNQ;
            if (raw_room) begin
              res0.kind     = kvlt_pkg::KIND_VAL_CHAR;
              res0.ch       = ch;
              res0.char_pos = raw_count_q;
              n_res         = 2'd1;
              raw_count_d   = raw_inc;
            end
            // CR and LF do not extend the reported length
            if (ch != kvlt_pkg::CH_LF && ch != kvlt_pkg::CH_CR) begin
              kept_count_d = raw_room ? raw_inc : raw_count_q;
            end
          end
        end
        default: phase_d = PH_SKIP;
      endcase
    end

    res0.last = (n_res == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_lim_q   <= kvlt_pkg::FIELD_LIMIT;
      max_len_q     <= kvlt_pkg::STORE_LIMIT;
      phase_q       <= PH_SKIP;
      field_total_q <= '0;
      raw_count_q   <= '0;
      kept_count_q  <= '0;
      halted_q      <= 1'b0;
      wr_ptr_q      <= '0;
      rd_ptr_q      <= '0;
      cnt_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          kvlt_pkg::CFG_FIELD_LIM: field_lim_q <= cfg_data_i[4:0];
          kvlt_pkg::CFG_MAX_LEN:   max_len_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        phase_q       <= phase_d;
        field_total_q <= field_total_d;
        raw_count_q   <= raw_count_d;
        kept_count_q  <= kept_count_d;
        halted_q      <= halted_d;
        wr_ptr_q      <= wr_ptr_q + n_res;
      end
      if (out_acc) rd_ptr_q <= rd_ptr_q + 2'd1;
      cnt_q <= cnt_q + ((in_acc) ? {1'b0, n_res} : 3'd0) - {2'b00, out_acc};
    end
  end

  // result queue payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc && n_res != 2'd0) queue_q[wr_ptr_q] <= res0;
    if (in_acc && n_res == 2'd2) queue_q[wr_ptr_q + 2'd1] <= res1;
  end

  assign head           = queue_q[rd_ptr_q];
  assign m_axis_tdata_o = {head.fields_found, head.final_len, head.field_pos,
                           head.char_pos, head.ch};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

  `KVLT_ASSERT(a_queue_bound, cnt_q <= 3'd4)
  `KVLT_ASSERT(a_pair_ends_line,
    (in_acc && n_res == 2'd2) |-> res1.kind == kvlt_pkg::KIND_LINE_DONE)
  `KVLT_ASSERT(a_line_restart, (in_acc && is_eol) |=> (phase_q == PH_SKIP && field_total_q == 5'd0))
  `KVLT_ASSERT(a_kept_le_raw, kept_count_q <= raw_count_q && raw_count_q <= 7'd99)
  `KVLT_ASSERT(a_line_done_last,
    (m_axis_tvalid_o && m_axis_tuser_o == kvlt_pkg::KIND_LINE_DONE) |-> m_axis_tlast_o)

endmodule
